// ===== rtl/core/tbce_pkg.sv =====
// Shared constants, codes and types of the terrain bitmap collision engine.
// No dependencies.
package tbce_pkg;

    localparam int WORD_BITS      = 32;
    localparam int WORD_SHIFT     = 5;
    localparam int COORD_W        = 14;
    localparam int DEF_MAP_WIDTH  = 1024;
    localparam int DEF_MAP_HEIGHT = 512;

    localparam int GROUND_TOP = 420;
    localparam int BAR_TOP    = 200;
    localparam int BAR_ROWS   = 10;
    localparam int BAR_LEN    = 300;
    localparam int BAR_A_LEFT = 200;
    localparam int BAR_B_LEFT = 700;

    localparam logic [2:0] OP_POINT   = 3'd0;
    localparam logic [2:0] OP_RECT    = 3'd1;
    localparam logic [2:0] OP_DESTROY = 3'd2;
    localparam logic [2:0] OP_GROUND  = 3'd3;
    localparam logic [2:0] OP_ROOF    = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_EV,
        ST_ADJ,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/terrain_bitmap_collision_engine_top.sv =====
// Top level of the terrain bitmap collision engine: word memory, sequencer, output register.
// Depends on tbce_pkg.

// The bitmap sits in one word-wide memory (32 pixels a word, one row = ceil(MAP_WIDTH/32)
// words) with a registered read; every request is served by a sequencer over that
// single port, one request at a time. After reset a load pass writes the starting terrain,
// one word a cycle, MAP_HEIGHT*ceil(MAP_WIDTH/32) words (16384 at the default size), with
// in_ready low. Out-of-range or unknown requests go straight to the output; a point query
// reads one word; a rectangle query reads each word touched, ending early on the first set
// pixel; a circle destroy rewrites each word of each disc row, with row span updates in
// between; ground and roof scans read one row per step. A finished result waits in the
// output register while the next request is accepted.
module terrain_bitmap_collision_engine_top
    import tbce_pkg::*;
#(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [11:0] pos_x,
    input  logic signed [11:0] pos_y,
    input  logic [10:0]        rect_width,
    input  logic [9:0]         rect_height,
    input  logic [7:0]         radius,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [11:0] result_y
);

    localparam int WPR    = (MAP_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int DEPTH  = MAP_HEIGHT * WPR;
    localparam int AW     = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(MAP_HEIGHT);
    localparam coord_t MAP_W_C = coord_t'(MAP_WIDTH);
    localparam coord_t MAP_H_C = coord_t'(MAP_HEIGHT);

    logic [WORD_BITS-1:0] map_mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    state_t state_reg, state_next;

    logic [2:0]         op_reg, op_next;
    coord_t             x_reg, x_next;
    coord_t             y_reg, y_next;
    coord_t             row_reg, row_next;
    coord_t             row_end_reg, row_end_next;
    coord_t             col_lo_reg, col_lo_next;
    coord_t             col_hi_reg, col_hi_next;
    coord_t             scan_y_reg, scan_y_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;
    logic [WIDX_W-1:0]  wbeg_reg, wbeg_next;
    logic [WIDX_W-1:0]  wend_reg, wend_next;
    logic [7:0]         r_reg, r_next;
    logic [15:0]        r2_reg, r2_next;
    logic [7:0]         hw_reg, hw_next;
    logic [15:0]        hw_sq_reg, hw_sq_next;
    logic signed [9:0]  dy_reg, dy_next;
    logic [15:0]        dy_sq_reg, dy_sq_next;
    logic               res_hit_reg, res_hit_next;
    coord_t             res_y_reg, res_y_next;
    logic [ROW_W-1:0]   init_row_reg, init_row_next;
    logic [WIDX_W-1:0]  init_widx_reg, init_widx_next;
    logic               out_valid_reg, out_valid_next;
    logic               hit_reg, hit_next;
    logic signed [11:0] result_y_reg, result_y_next;

    logic                 acc, out_load, mem_we, init_last;
    logic [ROW_W-1:0]     row_sel;
    logic [WIDX_W-1:0]    widx_sel;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata, mask, init_word;
    coord_t               col_base;
    coord_t               in_x, in_y, rx_s, rx_e, ry_s, ry_e, rx_x, ry_x;
    logic                 pt_in, rect_ok, col_ok, any_hit, w_last, r_last, dy_last;
    logic [17:0]          up_sum, dn_sum;
    logic                 adj_up, adj_dn;
    coord_t               sp_row, sp_lo, sp_hi, sp_xs, sp_xe;
    logic                 span_ok;
    logic                 is_ground, sc_stop, sc_free;
    coord_t               sc_t;

    function automatic logic [WORD_BITS-1:0] start_word(logic [ROW_W-1:0] row,
                                                        logic [WIDX_W-1:0] widx);
        logic [WORD_BITS-1:0] w;
        int col;
        int r;
        logic bar_row;
        w = '0;
        r = int'(row);
        bar_row = (r >= BAR_TOP) && (r < BAR_TOP + BAR_ROWS);
        for (int b = 0; b < WORD_BITS; b++) begin
            col = int'(widx) * WORD_BITS + b;
            w[b] = (col < MAP_WIDTH) &&
                   ((r >= GROUND_TOP) ||
                    (bar_row && (((col >= BAR_A_LEFT) && (col < BAR_A_LEFT + BAR_LEN)) ||
                                 ((col >= BAR_B_LEFT) && (col < BAR_B_LEFT + BAR_LEN)))));
        end
        return w;
    endfunction

    assign acc       = in_valid && in_ready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign init_last = (init_row_reg == ROW_W'(MAP_HEIGHT - 1)) &&
                       (init_widx_reg == WIDX_W'(WPR - 1));

    assign row_sel   = (state_reg == ST_INIT) ? init_row_reg : row_reg[ROW_W-1:0];
    assign widx_sel  = (state_reg == ST_INIT) ? init_widx_reg : widx_reg;
    assign mem_addr  = AW'(AW'(row_sel) * AW'(WPR) + AW'(widx_sel));
    assign init_word = start_word(init_row_reg, init_widx_reg);

    assign col_base = coord_t'({widx_reg, {WORD_SHIFT{1'b0}}});
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ((col_base + coord_t'(b)) >= col_lo_reg) &&
                      ((col_base + coord_t'(b)) <= col_hi_reg);
        end
    end

    assign mem_wdata = (state_reg == ST_INIT) ? init_word : (rdata_reg & ~mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= map_mem[mem_addr];
    end

    assign in_x   = coord_t'(pos_x);
    assign in_y   = coord_t'(pos_y);
    assign pt_in  = (in_x >= 0) && (in_x < MAP_W_C) && (in_y >= 0) && (in_y < MAP_H_C);
    assign col_ok = (in_x >= 0) && (in_x < MAP_W_C);
    assign rx_x   = in_x + coord_t'(rect_width);
    assign ry_x   = in_y + coord_t'(rect_height);
    assign rx_s   = (in_x < 0) ? '0 : in_x;
    assign ry_s   = (in_y < 0) ? '0 : in_y;
    assign rx_e   = ((rx_x > MAP_W_C) ? MAP_W_C : rx_x) - coord_t'(1);
    assign ry_e   = ((ry_x > MAP_H_C) ? MAP_H_C : ry_x) - coord_t'(1);
    assign rect_ok = (rx_s <= rx_e) && (ry_s <= ry_e);

    assign any_hit = |(rdata_reg & mask);
    assign w_last  = (widx_reg == wend_reg);
    assign r_last  = (row_reg == row_end_reg);
    assign dy_last = (dy_reg == $signed({2'b00, r_reg}));

    assign up_sum  = 18'(hw_sq_reg) + 18'({hw_reg, 1'b0}) + 18'd1 + 18'(dy_sq_reg);
    assign dn_sum  = 18'(hw_sq_reg) + 18'(dy_sq_reg);
    assign adj_up  = (up_sum <= 18'(r2_reg));
    assign adj_dn  = (dn_sum > 18'(r2_reg));
    assign sp_row  = y_reg + coord_t'(dy_reg);
    assign sp_lo   = x_reg - coord_t'(hw_reg);
    assign sp_hi   = x_reg + coord_t'(hw_reg);
    assign sp_xs   = (sp_lo < 0) ? '0 : sp_lo;
    assign sp_xe   = (sp_hi > MAP_W_C - coord_t'(1)) ? (MAP_W_C - coord_t'(1)) : sp_hi;
    assign span_ok = (sp_row >= 0) && (sp_row < MAP_H_C) && (sp_xs <= sp_xe);

    assign is_ground = (op_reg == OP_GROUND);
    assign sc_stop   = is_ground ? (scan_y_reg <= 0) : (scan_y_reg >= MAP_H_C - coord_t'(1));
    assign sc_t      = is_ground ? (scan_y_reg - coord_t'(1)) : (scan_y_reg + coord_t'(1));
    assign sc_free   = is_ground ? (sc_t >= MAP_H_C) : (sc_t < 0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (operation)
                        OP_POINT:   state_next = pt_in ? ST_RD : ST_OUT;
                        OP_RECT:    state_next = rect_ok ? ST_RD : ST_OUT;
                        OP_DESTROY: state_next = ST_ADJ;
                        OP_GROUND,
                        OP_ROOF:    state_next = col_ok ? ST_SCAN : ST_OUT;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_SCAN: state_next = (sc_stop || sc_free) ? ST_OUT : ST_RD;
            ST_RD:   state_next = ST_EV;
            ST_EV:
            begin
                unique case (op_reg)
                    OP_POINT:   state_next = ST_OUT;
                    OP_RECT:    state_next = (any_hit || (w_last && r_last)) ? ST_OUT : ST_RD;
                    OP_DESTROY: state_next = !w_last ? ST_RD : (dy_last ? ST_OUT : ST_ADJ);
                    default:    state_next = any_hit ? ST_SCAN : ST_OUT;
                endcase
            end
            ST_ADJ:
            begin
                priority if (adj_up || adj_dn)
                    state_next = ST_ADJ;
                else if (span_ok)
                    state_next = ST_RD;
                else if (dy_last)
                    state_next = ST_OUT;
                else
                    state_next = ST_ADJ;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        mem_we   = (state_reg == ST_INIT) || ((state_reg == ST_EV) && (op_reg == OP_DESTROY));
    end

    always_comb
    begin
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        row_next       = row_reg;
        row_end_next   = row_end_reg;
        col_lo_next    = col_lo_reg;
        col_hi_next    = col_hi_reg;
        scan_y_next    = scan_y_reg;
        widx_next      = widx_reg;
        wbeg_next      = wbeg_reg;
        wend_next      = wend_reg;
        r_next         = r_reg;
        r2_next        = r2_reg;
        hw_next        = hw_reg;
        hw_sq_next     = hw_sq_reg;
        dy_next        = dy_reg;
        dy_sq_next     = dy_sq_reg;
        res_hit_next   = res_hit_reg;
        res_y_next     = res_y_reg;
        init_row_next  = init_row_reg;
        init_widx_next = init_widx_reg;
        hit_next       = hit_reg;
        result_y_next  = result_y_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_INIT:
            begin
                if (init_widx_reg == WIDX_W'(WPR - 1))
                begin
                    init_widx_next = '0;
                    init_row_next  = init_row_reg + 1'b1;
                end
                else
                begin
                    init_widx_next = init_widx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    op_next      = operation;
                    x_next       = in_x;
                    y_next       = in_y;
                    scan_y_next  = in_y;
                    res_hit_next = 1'b0;
                    res_y_next   = in_y;
                    r_next       = radius;
                    r2_next      = 16'(radius * radius);
                    hw_next      = '0;
                    hw_sq_next   = '0;
                    dy_next      = -$signed({2'b00, radius});
                    dy_sq_next   = 16'(radius * radius);
                    if (operation == OP_RECT)
                    begin
                        row_next     = ry_s;
                        row_end_next = ry_e;
                        col_lo_next  = rx_s;
                        col_hi_next  = rx_e;
                        widx_next    = rx_s[WORD_SHIFT +: WIDX_W];
                        wbeg_next    = rx_s[WORD_SHIFT +: WIDX_W];
                        wend_next    = rx_e[WORD_SHIFT +: WIDX_W];
                    end
                    else
                    begin
                        row_next    = in_y;
                        col_lo_next = in_x;
                        col_hi_next = in_x;
                        widx_next   = in_x[WORD_SHIFT +: WIDX_W];
                    end
                end
            end
            ST_SCAN:
            begin
                row_next = sc_t;
                if (!sc_stop && sc_free)
                    res_y_next = scan_y_reg;
            end
            ST_RD:
            begin
            end
            ST_EV:
            begin
                unique case (op_reg)
                    OP_POINT:
                    begin
                        res_hit_next = any_hit;
                    end
                    OP_RECT:
                    begin
                        res_hit_next = any_hit;
                        if (w_last)
                        begin
                            widx_next = wbeg_reg;
                            row_next  = row_reg + coord_t'(1);
                        end
                        else
                        begin
                            widx_next = widx_reg + 1'b1;
                        end
                    end
                    OP_DESTROY:
                    begin
                        if (!w_last)
                        begin
                            widx_next = widx_reg + 1'b1;
                        end
                        else if (!dy_last)
                        begin
                            dy_next    = dy_reg + 10'sd1;
                            dy_sq_next = 16'(18'($signed({2'b00, dy_sq_reg})) +
                                             (18'(dy_reg) <<< 1) + 18'sd1);
                        end
                    end
                    default:
                    begin
                        if (!any_hit)
                            res_y_next = scan_y_reg;
                        else
                            scan_y_next = sc_t;
                    end
                endcase
            end
            ST_ADJ:
            begin
                priority if (adj_up)
                begin
                    hw_next    = hw_reg + 8'd1;
                    hw_sq_next = 16'(up_sum - 18'(dy_sq_reg));
                end
                else if (adj_dn)
                begin
                    hw_next    = hw_reg - 8'd1;
                    hw_sq_next = 16'(18'(hw_sq_reg) - 18'({hw_reg, 1'b0}) + 18'd1);
                end
                else if (span_ok)
                begin
                    row_next    = sp_row;
                    col_lo_next = sp_xs;
                    col_hi_next = sp_xe;
                    widx_next   = sp_xs[WORD_SHIFT +: WIDX_W];
                    wbeg_next   = sp_xs[WORD_SHIFT +: WIDX_W];
                    wend_next   = sp_xe[WORD_SHIFT +: WIDX_W];
                end
                else if (!dy_last)
                begin
                    dy_next    = dy_reg + 10'sd1;
                    dy_sq_next = 16'(18'($signed({2'b00, dy_sq_reg})) +
                                     (18'(dy_reg) <<< 1) + 18'sd1);
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    result_y_next  = res_y_reg[11:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_row_reg  <= '0;
            init_widx_reg <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_POINT;
        end
        else
        begin
            state_reg     <= state_next;
            init_row_reg  <= init_row_next;
            init_widx_reg <= init_widx_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        row_reg      <= row_next;
        row_end_reg  <= row_end_next;
        col_lo_reg   <= col_lo_next;
        col_hi_reg   <= col_hi_next;
        scan_y_reg   <= scan_y_next;
        widx_reg     <= widx_next;
        wbeg_reg     <= wbeg_next;
        wend_reg     <= wend_next;
        r_reg        <= r_next;
        r2_reg       <= r2_next;
        hw_reg       <= hw_next;
        hw_sq_reg    <= hw_sq_next;
        dy_reg       <= dy_next;
        dy_sq_reg    <= dy_sq_next;
        res_hit_reg  <= res_hit_next;
        res_y_reg    <= res_y_next;
        hit_reg      <= hit_next;
        result_y_reg <= result_y_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign result_y  = result_y_reg;

endmodule

// ===== rtl/core/tbce_checker.sv =====
// Port-level checks of the terrain bitmap collision engine, bound to the top level.
// Depends on tbce_pkg and terrain_bitmap_collision_engine_top.
module tbce_checker
    import tbce_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         operation,
    input logic signed [11:0] pos_x,
    input logic signed [11:0] pos_y,
    input logic [10:0]        rect_width,
    input logic [9:0]         rect_height,
    input logic [7:0]         radius,
    input logic               out_valid,
    input logic               out_ready,
    input logic               hit,
    input logic signed [11:0] result_y
);

    logic               in_acc, out_acc;
    logic [1:0]         cnt_reg;
    logic [2:0]         q0_op_reg, q1_op_reg;
    logic signed [11:0] q0_y_reg, q1_y_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk)
    begin
        if (out_acc)
        begin
            q0_op_reg <= q1_op_reg;
            q0_y_reg  <= q1_y_reg;
        end
        if (in_acc)
        begin
            if ((cnt_reg - 2'(out_acc)) == 2'd0)
            begin
                q0_op_reg <= operation;
                q0_y_reg  <= pos_y;
            end
            else
            begin
                q1_op_reg <= operation;
                q1_y_reg  <= pos_y;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(result_y))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 2'd0)
        else $error("result without a request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("too many requests in flight");

    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && q0_op_reg != OP_POINT && q0_op_reg != OP_RECT |-> !hit)
        else $error("hit set for a non-query request");

    a_row_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && q0_op_reg != OP_GROUND && q0_op_reg != OP_ROOF |-> result_y == q0_y_reg)
        else $error("row changed for a non-scan request");

endmodule

bind terrain_bitmap_collision_engine_top tbce_checker u_tbce_checker (.*);

// ===== test/tb_terrain_bitmap_collision_engine_top.sv =====
// Testbench for terrain_bitmap_collision_engine_top: random and directed requests checked
// against an in-bench bitmap predictor, with idle and stall phases on both channels.
// Depends on tbce_pkg and the engine top level.
module tb_terrain_bitmap_collision_engine_top;
    import tbce_pkg::*;

    localparam int MW = DEF_MAP_WIDTH;
    localparam int MH = DEF_MAP_HEIGHT;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [10:0]        w;
        logic [9:0]         h;
        logic [7:0]         r;
    } request_t;

    typedef struct packed {
        logic               hit;
        logic signed [11:0] ry;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         operation = '0;
    logic signed [11:0] pos_x = '0;
    logic signed [11:0] pos_y = '0;
    logic [10:0]        rect_width = '0;
    logic [9:0]         rect_height = '0;
    logic [7:0]         radius = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               hit;
    logic signed [11:0] result_y;

    bit       terrain [MW][MH];
    request_t pending_requests [$];
    answer_t  expected_answers [$];
    int       error_count = 0;
    int       answers_seen = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       req_taken = 0;

    terrain_bitmap_collision_engine_top uut (.*);

    always #6 clk = ~clk;

    function automatic bit pixel(int x, int y);
        if (x < 0 || x >= MW || y < 0 || y >= MH)
            return 0;
        return terrain[x][y];
    endfunction

    function automatic answer_t apply_request(request_t q);
        answer_t a;
        int x, y, xs, ys, xe, ye, r;
        a.hit = 0;
        a.ry = q.y;
        x = q.x;
        y = q.y;
        r = q.r;
        case (q.op)
            OP_POINT: a.hit = pixel(x, y);
            OP_RECT:
            begin
                xs = x < 0 ? 0 : x;
                ys = y < 0 ? 0 : y;
                xe = x + q.w;
                ye = y + q.h;
                if (xe > MW) xe = MW;
                if (ye > MH) ye = MH;
                for (int i = xs; i < xe && !a.hit; i++)
                    for (int j = ys; j < ye; j++)
                        if (terrain[i][j])
                        begin
                            a.hit = 1;
                            break;
                        end
            end
            OP_DESTROY:
            begin
                for (int dx = -r; dx <= r; dx++)
                    for (int dy = -r; dy <= r; dy++)
                        if (dx * dx + dy * dy <= r * r && x + dx >= 0 && x + dx < MW
                            && y + dy >= 0 && y + dy < MH)
                            terrain[x + dx][y + dy] = 0;
            end
            OP_GROUND:
            begin
                if (x >= 0 && x < MW)
                    for (int j = y; j > 0; j--)
                        if (!pixel(x, j - 1))
                        begin
                            a.ry = j;
                            break;
                        end
            end
            OP_ROOF:
            begin
                if (x >= 0 && x < MW)
                    for (int j = y; j < MH - 1; j++)
                        if (!pixel(x, j + 1))
                        begin
                            a.ry = j;
                            break;
                        end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (req_taken)
                    void'(pending_requests.pop_front());
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    operation <= pending_requests[0].op;
                    pos_x <= pending_requests[0].x;
                    pos_y <= pending_requests[0].y;
                    rect_width <= pending_requests[0].w;
                    rect_height <= pending_requests[0].h;
                    radius <= pending_requests[0].r;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on accept, check on result
    always @(posedge clk)
    begin
        req_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_answers.push_back(apply_request(pending_requests[0]));
        if (rst_n && out_valid && out_ready)
        begin
            answers_seen++;
            if (expected_answers.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                if (hit !== expected_answers[0].hit)
                    report_mismatch("hit", hit, expected_answers[0].hit);
                if (result_y !== expected_answers[0].ry)
                    report_mismatch("result_y", result_y, expected_answers[0].ry);
                void'(expected_answers.pop_front());
            end
        end
    end

    function automatic request_t make_request(int op, int x, int y, int w, int h, int r);
        request_t q;
        q.op = op;
        q.x = x;
        q.y = y;
        q.w = w;
        q.h = h;
        q.r = r;
        return q;
    endfunction

    function automatic request_t random_request();
        request_t q;
        int k;
        q.op = $urandom_range(4);
        if ($urandom_range(19) == 0)
            q.op = $urandom_range(7);
        if ($urandom_range(9) == 0)
        begin
            q.x = $urandom;
            q.y = $urandom;
        end
        else
        begin
            q.x = $urandom_range(MW + 20) - 10;
            q.y = $urandom_range(MH + 20) - 10;
        end
        k = $urandom_range(9);
        q.w = k == 0 ? $urandom_range(2047) : (k == 1 ? 1024 : $urandom_range(40));
        k = $urandom_range(9);
        q.h = k == 0 ? $urandom_range(1023) : (k == 1 ? 512 : $urandom_range(30));
        k = $urandom_range(19);
        q.r = k == 0 ? $urandom_range(255) : $urandom_range(24);
        // keep costly scans near the terrain features half of the time
        if ((q.op == OP_GROUND || q.op == OP_ROOF) && $urandom_range(1))
            q.y = $urandom_range(1) ? $urandom_range(440, 400) : $urandom_range(212, 196);
        return q;
    endfunction

    initial
    begin
        for (int x = 0; x < MW; x++)
            for (int y = 0; y < MH; y++)
                terrain[x][y] = (y >= GROUND_TOP) ||
                    (y >= BAR_TOP && y < BAR_TOP + BAR_ROWS &&
                     ((x >= BAR_A_LEFT && x < BAR_A_LEFT + BAR_LEN) ||
                      (x >= BAR_B_LEFT && x < BAR_B_LEFT + BAR_LEN)));
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_requests.push_back(make_request(OP_POINT, 0, 420, 0, 0, 0));
        pending_requests.push_back(make_request(OP_POINT, 1023, 511, 0, 0, 0));
        pending_requests.push_back(make_request(OP_POINT, -2048, 2047, 0, 0, 0));
        pending_requests.push_back(make_request(OP_POINT, 2047, -2048, 0, 0, 0));
        pending_requests.push_back(make_request(OP_POINT, 250, 205, 0, 0, 0));
        pending_requests.push_back(make_request(OP_RECT, 0, 0, 1024, 512, 0));
        pending_requests.push_back(make_request(OP_RECT, 0, 0, 2047, 1023, 0));
        pending_requests.push_back(make_request(OP_RECT, 10, 410, 0, 100, 0));
        pending_requests.push_back(make_request(OP_RECT, 10, 410, 100, 0, 0));
        pending_requests.push_back(make_request(OP_RECT, -100, -100, 150, 150, 0));
        pending_requests.push_back(make_request(OP_GROUND, 300, 205, 0, 0, 0));
        pending_requests.push_back(make_request(OP_ROOF, 300, 195, 0, 0, 0));
        pending_requests.push_back(make_request(OP_GROUND, -1, 450, 0, 0, 0));
        pending_requests.push_back(make_request(OP_ROOF, 1024, 300, 0, 0, 0));
        pending_requests.push_back(make_request(OP_GROUND, 5, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_ROOF, 5, 511, 0, 0, 0));
        pending_requests.push_back(make_request(OP_GROUND, 5, 511, 0, 0, 0));
        pending_requests.push_back(make_request(OP_DESTROY, 0, 511, 0, 0, 255));
        pending_requests.push_back(make_request(OP_DESTROY, -5, 430, 0, 0, 20));
        pending_requests.push_back(make_request(OP_DESTROY, 600, 420, 0, 0, 0));
        pending_requests.push_back(make_request(OP_DESTROY, 2047, 2047, 0, 0, 255));
        pending_requests.push_back(make_request(OP_ROOF, 600, 419, 0, 0, 0));
        pending_requests.push_back(make_request(5, 1, 2, 3, 4, 5));
        pending_requests.push_back(make_request(7, -1, -1, 2047, 1023, 255));

        for (int phase = 0; phase < 5; phase++)
        begin
            send_idle_pct = phase == 1 ? 70 : (phase == 3 ? 16 : 0);
            recv_stall_pct = phase == 2 ? 70 : (phase == 3 ? 16 : 0);
            for (int i = 0; i < 140; i++)
                pending_requests.push_back(random_request());
            wait (pending_requests.size() == 0);
        end
        wait (expected_answers.size() == 0);
        repeat (600) @(posedge clk);
        $display("Covered %0d results over five idle/stall phases,", answers_seen);
        $display("all five operations plus unknown codes and out-of-map coordinates.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
